// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the telnet line console RTL.
// Depends on nothing; included inside module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define TIC_ASSERT_ALWAYS(label, clk_s, rstn_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error("tic: invariant violated");

// Antecedent implies consequent in the same cycle.
`define TIC_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("tic: implication violated");

// Antecedent implies consequent in the next cycle.
`define TIC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("tic: next-cycle property violated");

`endif

// ----- hdl/tic_pkg.sv -----
// Package for the telnet line console: codes, row layout, constant text ROM.
// No dependencies; imported by the parser and the top level.
package tic_pkg;

    localparam int DEF_CONNECTIONS = 4;
    localparam int DEF_LINE_BYTES  = 32;
    localparam int LEN_W           = 6;
    localparam int ROM_W           = 5;

    // request codes
    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_COUNT = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_CLIENT = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_COUNT  = 2'd3;

    // telnet command bytes
    localparam logic [7:0] TN_SE   = 8'd240;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] OPTION_ECHO = 8'd1;
    localparam logic [7:0] OPTION_SGA  = 8'd3;

    // line editing bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // parser state codes as stored in the row memory
    localparam logic [2:0] PS_NORMAL  = 3'd0;
    localparam logic [2:0] PS_IAC     = 3'd1;
    localparam logic [2:0] PS_OPT     = 3'd2;
    localparam logic [2:0] PS_SUB     = 3'd3;
    localparam logic [2:0] PS_SUB_IAC = 3'd4;

    // pending verb, stored as offset from WILL
    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    // text ROM layout: greeting, its tail doubles as CR LF and prompt, then erase
    localparam logic [ROM_W-1:0] ROM_GREET_FIRST  = 5'd0;
    localparam logic [ROM_W-1:0] ROM_GREET_LAST   = 5'd24;
    localparam logic [ROM_W-1:0] ROM_CRLF_FIRST   = 5'd21;
    localparam logic [ROM_W-1:0] ROM_CRLF_LAST    = 5'd22;
    localparam logic [ROM_W-1:0] ROM_PROMPT_FIRST = 5'd23;
    localparam logic [ROM_W-1:0] ROM_PROMPT_LAST  = 5'd24;
    localparam logic [ROM_W-1:0] ROM_ERASE_FIRST  = 5'd25;
    localparam logic [ROM_W-1:0] ROM_ERASE_LAST   = 5'd27;

    typedef struct packed {
        logic [2:0]       ps;
        logic [1:0]       verb;
        logic             cr;
        logic [LEN_W-1:0] len;
    } row_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_BYTES,
        ACT_ERASE,
        ACT_LINE
    } act_kind_t;

    typedef struct packed {
        act_kind_t  kind;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       store;
    } tic_act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ROM,
        ST_TRIO,
        ST_LINE_ADDR,
        ST_LINE_DATA,
        ST_LINE_END,
        ST_COUNT
    } state_t;

    function automatic logic [7:0] tic_rom_byte(input logic [ROM_W-1:0] idx);
        logic [7:0] r;
        unique case (idx)
            5'd0:    r = TN_IAC;
            5'd1:    r = TN_WILL;
            5'd2:    r = OPTION_ECHO;
            5'd3:    r = TN_IAC;
            5'd4:    r = TN_WILL;
            5'd5:    r = OPTION_SGA;
            5'd6:    r = 8'h50; // P
            5'd7:    r = 8'h43; // C
            5'd8:    r = 8'h20;
            5'd9:    r = 8'h54; // T
            5'd10:   r = 8'h65; // e
            5'd11:   r = 8'h6C; // l
            5'd12:   r = 8'h6E; // n
            5'd13:   r = 8'h65; // e
            5'd14:   r = 8'h74; // t
            5'd15:   r = 8'h20;
            5'd16:   r = 8'h72; // r
            5'd17:   r = 8'h65; // e
            5'd18:   r = 8'h61; // a
            5'd19:   r = 8'h64; // d
            5'd20:   r = 8'h79; // y
            5'd21:   r = CH_CR;
            5'd22:   r = CH_LF;
            5'd23:   r = 8'h3E; // >
            5'd24:   r = CH_SPACE;
            5'd25:   r = CH_BS;
            5'd26:   r = CH_SPACE;
            5'd27:   r = CH_BS;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/tic_if.sv -----
// Valid/ready channel interfaces for the telnet line console.
// No dependencies; used by the top-level ports.
interface tic_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [1:0] conn;
    logic [7:0] rx_byte;

    modport source (output valid, op, conn, rx_byte, input ready);
    modport sink   (input valid, op, conn, rx_byte, output ready);
endinterface

interface tic_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_conn;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, out_conn, kind, value, last, input ready);
    modport sink   (input valid, out_conn, kind, value, last, output ready);
endinterface

// ----- hdl/telnet_iac_line_console_core.sv -----
// Top level of the telnet line console: sequencer, row memory, line memory.
// Depends on tic_pkg, tic_if, tic_ram, tic_parse and assert_macros.svh.
//
//   channel | dir | payload                        | transaction when
//   --------+-----+--------------------------------+------------------------
//   cmd     | in  | op, conn, rx_byte              | cmd.valid && cmd.ready
//   res     | out | out_conn, kind, value, last    | res.valid && res.ready
//
// A silent received byte is accepted with a row read, then its row is
// modified and written back. A line byte is read from the line memory in
// ST_LINE_ADDR and pushed in ST_LINE_DATA. Open clears the row and sends the
// greeting. Reset clears open flags, their count, output valid and the FSM
// only; rows are rewritten on open, so no clearing pass runs.
// One output register decouples the sides: a new request is taken while the
// last result of the previous one still waits; downstream stalls hold the FSM.
module telnet_iac_line_console_core #(
    parameter int CONNECTIONS = tic_pkg::DEF_CONNECTIONS,
    parameter int LINE_BYTES  = tic_pkg::DEF_LINE_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    tic_cmd_if.sink          cmd,
    tic_res_if.source        res
);
    import tic_pkg::*;

    `include "assert_macros.svh"

    localparam int ROW_AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int IDX_W  = $clog2(LINE_BYTES);
    localparam int LS_DEPTH = CONNECTIONS * (2 ** IDX_W);
    localparam int LS_AW  = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
    localparam int CNT_W  = $clog2(CONNECTIONS + 1);
    localparam int ROW_W  = $bits(row_t);

    // FSM and request registers
    state_t              state_reg, state_next;
    logic [1:0]          conn_reg, conn_next;
    logic [ROW_AW-1:0]   row_reg, row_next_idx;
    logic [7:0]          byte_reg, byte_next;

    // constant text walker
    logic [ROM_W-1:0]    rom_ptr_reg, rom_ptr_next;
    logic [ROM_W-1:0]    rom_end_reg, rom_end_next;
    logic                rom_last_reg, rom_last_next;
    state_t              rom_ret_reg, rom_ret_next;

    // line dispatch and short byte runs
    logic [LEN_W-1:0]    line_n_reg, line_n_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [2:0][7:0]     trio_reg, trio_next;
    logic [1:0]          trio_cnt_reg, trio_cnt_next;
    logic [1:0]          trio_k_reg, trio_k_next;
    logic [7:0]          trio_byte;

    // open flags and their count
    logic [CONNECTIONS-1:0] open_reg, open_next;
    logic [CNT_W-1:0]       open_cnt_reg, open_cnt_next;

    // output register
    logic                ov_reg;
    logic [1:0]          oconn_reg;
    logic [1:0]          okind_reg;
    logic [7:0]          oval_reg;
    logic                olast_reg;
    logic                can_push;
    logic                push_en;
    logic [1:0]          push_kind;
    logic [7:0]          push_val;
    logic                push_last;

    // memory ports
    logic                row_we, row_re;
    logic [ROW_AW-1:0]   row_waddr;
    row_t                row_wdata, row_rdata, row_upd;
    tic_act_t            act;
    logic                ls_we, ls_re;
    logic [LS_AW-1:0]    ls_waddr, ls_raddr;
    logic [7:0]          ls_rdata;

    // incoming request decode
    logic [3:0]          conn_wide;
    logic [ROW_AW-1:0]   acc_row;
    logic                in_range;
    logic                acc;

    assign conn_wide = {2'b00, cmd.conn};
    assign acc_row   = conn_wide[ROW_AW-1:0];
    assign in_range  = {1'b0, conn_wide} < 5'(CONNECTIONS);
    assign cmd.ready = (state_reg == ST_IDLE);
    assign acc       = cmd.valid && cmd.ready;
    assign can_push  = !ov_reg || res.ready;

    assign res.valid    = ov_reg;
    assign res.out_conn = oconn_reg;
    assign res.kind     = okind_reg;
    assign res.value    = oval_reg;
    assign res.last     = olast_reg;

    tic_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CONNECTIONS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (acc_row),
        .rdata (row_rdata)
    );

    tic_ram #(
        .WIDTH (8),
        .DEPTH (LS_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (byte_reg),
        .re    (ls_re),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    tic_parse #(
        .LINE_BYTES (LINE_BYTES)
    ) u_parse (
        .row      (row_rdata),
        .rx_byte  (byte_reg),
        .row_next (row_upd),
        .act      (act)
    );

    always_comb
    begin
        unique case (trio_k_reg)
            2'd0:    trio_byte = trio_reg[0];
            2'd1:    trio_byte = trio_reg[1];
            default: trio_byte = trio_reg[2];
        endcase
    end

    // next state, memory controls and result pushes
    always_comb
    begin
        state_next    = state_reg;
        conn_next     = conn_reg;
        row_next_idx  = row_reg;
        byte_next     = byte_reg;
        rom_ptr_next  = rom_ptr_reg;
        rom_end_next  = rom_end_reg;
        rom_last_next = rom_last_reg;
        rom_ret_next  = rom_ret_reg;
        line_n_next   = line_n_reg;
        idx_next      = idx_reg;
        trio_next     = trio_reg;
        trio_cnt_next = trio_cnt_reg;
        trio_k_next   = trio_k_reg;
        open_next     = open_reg;
        open_cnt_next = open_cnt_reg;

        push_en   = 1'b0;
        push_kind = KIND_CLIENT;
        push_val  = '0;
        push_last = 1'b0;

        row_we    = 1'b0;
        row_re    = 1'b0;
        row_waddr = row_reg;
        row_wdata = row_upd;
        ls_we     = 1'b0;
        ls_re     = 1'b0;
        ls_waddr  = LS_AW'({row_reg, row_rdata.len[IDX_W-1:0]});
        ls_raddr  = LS_AW'({row_reg, idx_reg[IDX_W-1:0]});

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    conn_next    = cmd.conn;
                    row_next_idx = acc_row;
                    byte_next    = cmd.rx_byte;
                    unique case (cmd.op)
                        OP_COUNT:
                        begin
                            state_next = ST_COUNT;
                        end
                        OP_OPEN:
                        begin
                            if (in_range)
                            begin
                                // clear the row and start the greeting
                                row_we    = 1'b1;
                                row_waddr = acc_row;
                                row_wdata = '0;
                                if (!open_reg[acc_row])
                                begin
                                    open_cnt_next = open_cnt_reg + 1'b1;
                                end
                                open_next[acc_row] = 1'b1;
                                rom_ptr_next  = ROM_GREET_FIRST;
                                rom_end_next  = ROM_GREET_LAST;
                                rom_last_next = 1'b1;
                                rom_ret_next  = ST_IDLE;
                                state_next    = ST_ROM;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (in_range && open_reg[acc_row])
                            begin
                                open_next[acc_row] = 1'b0;
                                open_cnt_next      = open_cnt_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            // received byte: fetch the row, write it back in ST_EXEC
                            if (in_range && open_reg[acc_row])
                            begin
                                row_re     = 1'b1;
                                state_next = ST_EXEC;
                            end
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                // write back the row; the read port is idle until we return
                row_we = 1'b1;
                ls_we  = act.store;
                unique case (act.kind)
                    ACT_BYTES:
                    begin
                        trio_next     = {act.b2, act.b1, act.b0};
                        trio_cnt_next = act.cnt;
                        trio_k_next   = 2'd0;
                        state_next    = ST_TRIO;
                    end
                    ACT_ERASE:
                    begin
                        rom_ptr_next  = ROM_ERASE_FIRST;
                        rom_end_next  = ROM_ERASE_LAST;
                        rom_last_next = 1'b1;
                        rom_ret_next  = ST_IDLE;
                        state_next    = ST_ROM;
                    end
                    ACT_LINE:
                    begin
                        line_n_next   = row_rdata.len;
                        idx_next      = '0;
                        rom_ptr_next  = ROM_CRLF_FIRST;
                        rom_end_next  = ROM_CRLF_LAST;
                        rom_last_next = 1'b0;
                        rom_ret_next  = ST_LINE_ADDR;
                        state_next    = ST_ROM;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ROM:
            begin
                if (can_push)
                begin
                    push_en   = 1'b1;
                    push_val  = tic_rom_byte(rom_ptr_reg);
                    push_last = rom_last_reg && (rom_ptr_reg == rom_end_reg);
                    if (rom_ptr_reg == rom_end_reg)
                    begin
                        state_next = rom_ret_reg;
                    end
                    else
                    begin
                        rom_ptr_next = rom_ptr_reg + 1'b1;
                    end
                end
            end
            ST_TRIO:
            begin
                if (can_push)
                begin
                    push_en   = 1'b1;
                    push_val  = trio_byte;
                    push_last = (trio_k_reg == trio_cnt_reg - 1'b1);
                    trio_k_next = trio_k_reg + 1'b1;
                    if (push_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LINE_ADDR:
            begin
                if (idx_reg == line_n_reg)
                begin
                    state_next = ST_LINE_END;
                end
                else
                begin
                    ls_re      = 1'b1;
                    state_next = ST_LINE_DATA;
                end
            end
            ST_LINE_DATA:
            begin
                // read data holds while the output stalls
                if (can_push)
                begin
                    push_en    = 1'b1;
                    push_kind  = KIND_LINE;
                    push_val   = ls_rdata;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LINE_ADDR;
                end
            end
            ST_LINE_END:
            begin
                if (can_push)
                begin
                    push_en       = 1'b1;
                    push_kind     = KIND_END;
                    push_val      = 8'(line_n_reg);
                    rom_ptr_next  = ROM_PROMPT_FIRST;
                    rom_end_next  = ROM_PROMPT_LAST;
                    rom_last_next = 1'b1;
                    rom_ret_next  = ST_IDLE;
                    state_next    = ST_ROM;
                end
            end
            ST_COUNT:
            begin
                if (can_push)
                begin
                    push_en    = 1'b1;
                    push_kind  = KIND_COUNT;
                    push_val   = 8'(open_cnt_reg);
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            open_reg     <= '0;
            open_cnt_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            open_reg     <= open_next;
            open_cnt_reg <= open_cnt_next;
            if (push_en)
            begin
                ov_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        conn_reg     <= conn_next;
        row_reg      <= row_next_idx;
        byte_reg     <= byte_next;
        rom_ptr_reg  <= rom_ptr_next;
        rom_end_reg  <= rom_end_next;
        rom_last_reg <= rom_last_next;
        rom_ret_reg  <= rom_ret_next;
        line_n_reg   <= line_n_next;
        idx_reg      <= idx_next;
        trio_reg     <= trio_next;
        trio_cnt_reg <= trio_cnt_next;
        trio_k_reg   <= trio_k_next;
        if (push_en)
        begin
            oconn_reg <= conn_reg;
            okind_reg <= push_kind;
            oval_reg  <= push_val;
            olast_reg <= push_last;
        end
    end

    // the running count must track the open flags
    `TIC_ASSERT_ALWAYS(a_open_cnt, clk, rst_n, open_cnt_reg == CNT_W'($countones(open_reg)))
    // the final result of a transaction always returns the sequencer to idle
    `TIC_ASSERT_NEXT(a_last_idle, clk, rst_n, push_en && push_last, state_reg == ST_IDLE)
    // a line byte fetch never runs past the captured line length
    `TIC_ASSERT_IMPLIES(a_line_idx, clk, rst_n, state_reg == ST_LINE_DATA, idx_reg < line_n_reg)

endmodule

// ----- hdl/tic_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hdl/tic_parse.sv -----
// Per-byte telnet parser and line editor: next row state and the action to run.
// Depends on tic_pkg.
module tic_parse #(
    parameter int LINE_BYTES = tic_pkg::DEF_LINE_BYTES
) (
    input  tic_pkg::row_t     row,
    input  logic [7:0]        rx_byte,
    output tic_pkg::row_t     row_next,
    output tic_pkg::tic_act_t act
);
    import tic_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

    logic       data_en;
    logic [7:0] reply;

    always_comb
    begin
        row_next  = row;
        act.kind  = ACT_NONE;
        act.cnt   = 2'd0;
        act.b0    = rx_byte;
        act.b1    = rx_byte;
        act.b2    = rx_byte;
        act.store = 1'b0;
        data_en   = 1'b0;
        reply     = CH_NUL;

        unique case (row.ps)
            PS_IAC:
            begin
                if (rx_byte == TN_SB)
                begin
                    row_next.ps = PS_SUB;
                end
                else if (rx_byte >= TN_WILL && rx_byte <= TN_DONT)
                begin
                    row_next.verb = 2'(rx_byte - TN_WILL);
                    row_next.ps   = PS_OPT;
                end
                else
                begin
                    // escaped IAC is a data 0xFF; other commands are consumed
                    row_next.ps = PS_NORMAL;
                    data_en     = (rx_byte == TN_IAC);
                end
            end
            PS_OPT:
            begin
                row_next.ps = PS_NORMAL;
                if (row.verb == VERB_DO && rx_byte != OPTION_ECHO && rx_byte != OPTION_SGA)
                begin
                    reply = TN_WONT;
                end
                else if (row.verb == VERB_WILL)
                begin
                    reply = TN_DONT;
                end
                if (reply != CH_NUL)
                begin
                    act.kind = ACT_BYTES;
                    act.cnt  = 2'd3;
                    act.b0   = TN_IAC;
                    act.b1   = reply;
                    act.b2   = rx_byte;
                end
            end
            PS_SUB:
            begin
                if (rx_byte == TN_IAC)
                begin
                    row_next.ps = PS_SUB_IAC;
                end
            end
            PS_SUB_IAC:
            begin
                row_next.ps = (rx_byte == TN_SE) ? PS_NORMAL : PS_SUB;
            end
            default:
            begin
                row_next.ps = (rx_byte == TN_IAC) ? PS_IAC : PS_NORMAL;
                data_en     = (rx_byte != TN_IAC);
            end
        endcase

        if (data_en)
        begin
            row_next.cr = 1'b0;
            priority if (row.cr && (rx_byte == CH_LF || rx_byte == CH_NUL))
            begin
                act.kind     = ACT_LINE;
                row_next.len = '0;
            end
            else if (rx_byte == CH_CR)
            begin
                row_next.cr = 1'b1;
            end
            else if (rx_byte == CH_LF)
            begin
                act.kind     = ACT_LINE;
                row_next.len = '0;
            end
            else if (rx_byte == CH_BS || rx_byte == CH_DEL)
            begin
                if (row.len != '0)
                begin
                    row_next.len = row.len - 1'b1;
                    act.kind     = ACT_ERASE;
                end
            end
            else if (rx_byte < CH_SPACE)
            begin
                // other control bytes: drop
            end
            else if (row.len < LEN_MAX)
            begin
                row_next.len = row.len + 1'b1;
                act.kind     = ACT_BYTES;
                act.store    = 1'b1;
                act.cnt      = (rx_byte == TN_IAC) ? 2'd2 : 2'd1;
            end
        end
    end
endmodule
